@@ src/awag_pkg.sv @@
`timescale 1ns / 1ps
package awag_pkg;

	localparam int DEF_MAX_DIM   = 4096;
	localparam int DEF_FRAC_BITS = 24;

	localparam int COEF_W    = 40;
	localparam int COORD_W   = 12;
	localparam int SIZE_W    = 13;
	localparam int IDX_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = COEF_W + COORD_W + 1;
	localparam int SUM_W     = PROD_W + 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_BASE    = 3'd0,
		REG_ROW_PER_COL = 3'd1,
		REG_ROW_PER_ROW = 3'd2,
		REG_COL_BASE    = 3'd3,
		REG_COL_PER_COL = 3'd4,
		REG_COL_PER_ROW = 3'd5,
		REG_SRC_ROWS    = 3'd6,
		REG_SRC_COLS    = 3'd7
	} reg_idx_t;

	// source index with its in-range flag
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} idx_t;

endpackage

@@ src/awag_index.sv @@
`timescale 1ns / 1ps
module awag_index import awag_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic signed [SUM_W-1:0]  value,
	input  logic        [SIZE_W-1:0] size,
	output idx_t                     index
);

	localparam logic signed [SUM_W-1:0] ONE     = SUM_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] NEG_ONE = -ONE;
	localparam logic        [SUM_W-1:0] DIM_CAP = SUM_W'(MAX_DIM);

	logic             neg;
	logic             below_range;
	logic [SUM_W-1:0] size_w;
	logic [SUM_W-1:0] lim;
	logic [SUM_W-1:0] q;

	always_comb begin
		neg         = value[SUM_W-1];
		below_range = neg && !(value > NEG_ONE);
		size_w      = SUM_W'(size);
		lim         = (size_w > DIM_CAP) ? DIM_CAP : size_w;
		// truncation toward zero: anything in (-1, 0) lands on zero
		q           = neg ? '0 : SUM_W'(value >>> FRAC_BITS);
		index.valid = !below_range && (q < lim);
		index.idx   = q[IDX_W-1:0];
	end

endmodule

@@ src/affine_warp_address_generator.sv @@
`timescale 1ns / 1ps
// Affine inverse-mapping address generator.
// Input stream (s_*): one output pixel per transfer; s_tdata holds out_row and
// out_col, s_tlast marks the last pixel of an output row.
// Output stream (m_*): one result per input transfer, in order; m_tdata holds
// the mapped source row and column (-1 when outside the source image) and the
// lowest and highest valid source row met so far in the current output row.
// m_tlast repeats the row-end flag; the row min/max tracking clears after it.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while the stream is idle.
// Pipeline: an input transfer passes the input register, registered products,
// registered sums and the result register before it shows on m_tvalid.
// Throughput: one pixel per cycle unless a stall holds it; the stages move together.
// Stall: when the result register is full and m_tready is low, every stage
// holds and s_tready drops; no transfer is lost.
// Reset: empties the pipeline, loads the identity transform and a
// 4096 x 4096 source, and clears the row tracking.
module affine_warp_address_generator import awag_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // out_row[11:0], out_col[23:12]
	input  logic                 s_tlast,

	output logic                 m_tvalid,
	input  logic                 m_tready,
	// src_row[12:0], src_col[25:13], row_min_seen[38:26], row_max_seen[51:39], zeros
	output logic [55:0]          m_tdata,
	output logic                 m_tlast
);

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;

	logic signed [COEF_W-1:0] row_base_q, row_per_col_q, row_per_row_q;
	logic signed [COEF_W-1:0] col_base_q, col_per_col_q, col_per_row_q;
	logic        [SIZE_W-1:0] src_rows_q, src_cols_q;

	logic adv;

	logic               valid_s1, last_s1;
	logic [COORD_W-1:0] row_s1, col_s1;

	logic                     valid_s2, last_s2;
	logic signed [PROD_W-1:0] rc_s2, rr_s2, cc_s2, cr_s2;

	logic                    valid_s3, last_s3;
	logic signed [SUM_W-1:0] rsum_s3, csum_s3;

	idx_t row_idx, col_idx;

	logic             run_valid_q;
	logic [IDX_W-1:0] run_min_q, run_max_q;
	logic             nxt_valid;
	logic [IDX_W-1:0] nxt_min, nxt_max;

	logic             m_tvalid_q, m_tlast_q;
	idx_t             res_row_q, res_col_q, res_min_q, res_max_q;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q    <= '0;
			row_per_col_q <= '0;
			row_per_row_q <= COEF_ONE;
			col_base_q    <= '0;
			col_per_col_q <= COEF_ONE;
			col_per_row_q <= '0;
			src_rows_q    <= SIZE_RESET;
			src_cols_q    <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROW_BASE:    row_base_q    <= cfg_data;
				REG_ROW_PER_COL: row_per_col_q <= cfg_data;
				REG_ROW_PER_ROW: row_per_row_q <= cfg_data;
				REG_COL_BASE:    col_base_q    <= cfg_data;
				REG_COL_PER_COL: col_per_col_q <= cfg_data;
				REG_COL_PER_ROW: col_per_row_q <= cfg_data;
				REG_SRC_ROWS:    src_rows_q    <= cfg_data[SIZE_W-1:0];
				REG_SRC_COLS:    src_cols_q    <= cfg_data[SIZE_W-1:0];
			endcase
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			valid_s1   <= s_tvalid;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			m_tvalid_q <= valid_s3;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1  <= s_tdata[11:0];
			col_s1  <= s_tdata[23:12];
			last_s1 <= s_tlast;

			rc_s2   <= PROD_W'(row_per_col_q) * PROD_W'($signed({1'b0, col_s1}));
			rr_s2   <= PROD_W'(row_per_row_q) * PROD_W'($signed({1'b0, row_s1}));
			cc_s2   <= PROD_W'(col_per_col_q) * PROD_W'($signed({1'b0, col_s1}));
			cr_s2   <= PROD_W'(col_per_row_q) * PROD_W'($signed({1'b0, row_s1}));
			last_s2 <= last_s1;

			rsum_s3 <= SUM_W'(row_base_q) + SUM_W'(rc_s2) + SUM_W'(rr_s2);
			csum_s3 <= SUM_W'(col_base_q) + SUM_W'(cc_s2) + SUM_W'(cr_s2);
			last_s3 <= last_s2;

			res_row_q <= row_idx;
			res_col_q <= col_idx;
			res_min_q <= '{valid: nxt_valid, idx: nxt_min};
			res_max_q <= '{valid: nxt_valid, idx: nxt_max};
			m_tlast_q <= last_s3;
		end
	end

	awag_index #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_row_index (
		.value (rsum_s3),
		.size  (src_rows_q),
		.index (row_idx)
	);

	awag_index #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_col_index (
		.value (csum_s3),
		.size  (src_cols_q),
		.index (col_idx)
	);

	// running source-row span of the current output row
	always_comb begin
		nxt_valid = run_valid_q;
		nxt_min   = run_min_q;
		nxt_max   = run_max_q;
		if (row_idx.valid) begin
			nxt_valid = 1'b1;
			priority if (!run_valid_q) begin
				nxt_min = row_idx.idx;
				nxt_max = row_idx.idx;
			end else if (row_idx.idx < run_min_q) begin
				nxt_min = row_idx.idx;
			end else if (row_idx.idx > run_max_q) begin
				nxt_max = row_idx.idx;
			end else begin
				nxt_min = run_min_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_min_q   <= '0;
			run_max_q   <= '0;
		end else if (adv && valid_s3) begin
			run_valid_q <= nxt_valid && !last_s3;
			run_min_q   <= nxt_min;
			run_max_q   <= nxt_max;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {4'b0,
		res_max_q.valid ? res_max_q.idx : {IDX_W{1'b1}},
		res_min_q.valid ? res_min_q.idx : {IDX_W{1'b1}},
		res_col_q.valid ? res_col_q.idx : {IDX_W{1'b1}},
		res_row_q.valid ? res_row_q.idx : {IDX_W{1'b1}}};

	// row tracking clears once the row-closing pixel moves from the sum stage into the result register
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s3 && last_s3 |=> !run_valid_q)
		else $error("row span not cleared after row end");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> run_min_q <= run_max_q)
		else $error("row span min above max");

	a_result_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && res_row_q.valid |->
			res_min_q.valid && res_max_q.valid &&
			res_min_q.idx <= res_row_q.idx && res_max_q.idx >= res_row_q.idx)
		else $error("reported span does not cover source row");

endmodule
